### rtl/cksum_pkg.sv
// Shared types, constants and the CRC byte step for the cksum block.
package cksum_pkg;

  // CRC-32 polynomial, MSB first, and the final inversion mask.
  localparam logic [31:0] CrcPoly   = 32'h04C1_1DB7;
  localparam logic [31:0] CrcXorOut = 32'hFFFF_FFFF;

  // Width of the running byte count (16 to 64); it wraps at this width.
  localparam int unsigned CountBits  = 64;
  // Width of the byte count as it leaves the block.
  localparam int unsigned ByteCountW = 64;

  // Command queue between the front and the back; the depth is a power of two.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_BYTE     = 2'd0,
    OP_BYTE_FIN = 2'd1,
    OP_FIN      = 2'd2
  } op_e;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic       has_byte;
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  // Write side of the queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Folds one byte into the CRC, most significant bit first.
  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

### rtl/cksum_if.sv
// Valid/ready channel interfaces for the request and result sides of the cksum block.
interface cksum_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface cksum_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;
  logic [63:0] byte_count;

  modport source (output valid, output checksum, output byte_count, input ready);
  modport sink   (input valid, input checksum, input byte_count, output ready);
endinterface

### rtl/posix_cksum_crc32.sv
// Top level of the POSIX cksum CRC-32 block: front end, command queue and CRC engine.
//
// Usage: requests arrive on data_i (op, data_byte) under valid/ready. Op 0 adds a
// message byte, op 1 adds a byte and finishes, op 2 (and the unused code 3)
// finishes without a byte. On finish, one result leaves on result_o carrying the
// inverted CRC-32 (length bytes folded in) and the message byte count.
// Throughput: one data byte per cycle while the engine is not busy with a finish,
// set by the single byte-wide CRC step in the engine. A finish occupies the engine
// while it walks L count bytes, where L (0 to 8) is the number of count bytes up
// to and including the highest non-zero byte, one byte per cycle, and then loads
// the result. A finishing request shows its result after it passes the queue, the
// length-byte walk in the engine and the output register.
// A two-entry queue lets requests keep arriving while the engine walks the
// length bytes or waits on the output. If the receiver stalls, the result stays
// in the output register, and the engine and then the queue fill before data_i
// drops ready.
// Reset (rst_ni low, asynchronous) empties the queue, clears the CRC and count
// and drops result_o.valid.
module posix_cksum_crc32
  import cksum_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cksum_in_if.sink    data_i,
  cksum_out_if.source result_o
);

  q_push_t push;
  q_head_t head;
  logic    full;
  logic    pop;

  cksum_front u_front (
    .data_i (data_i),
    .full_i (full),
    .push_o (push)
  );

  cksum_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  cksum_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  // The engine only takes a request that the queue actually holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head.valid)
    else $error("engine popped an empty queue");

  // A new result is only loaded while the engine walks length bytes, never on a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(result_o.valid) |-> !$past(pop))
    else $error("result loaded in a cycle that popped the queue");

  // A waiting request is not lost while the engine is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (head.valid && !pop) |=> head.valid)
    else $error("queued request vanished without a pop");
`endif

endmodule

### rtl/cksum_front.sv
// Front end: takes requests from the input channel and classifies them for the queue.
module cksum_front
  import cksum_pkg::*;
(
  cksum_in_if.sink       data_i,
  input  logic           full_i,
  output q_push_t        push_o
);

  logic [1:0] op_code;
  cmd_t       cmd;

  // A request is taken whenever the queue has room.
  assign data_i.ready = !full_i;
  assign op_code      = data_i.op;

  // Decode the operation; the unused code is handled as a plain finish.
  always_comb begin
    cmd.data = data_i.data_byte;
    case (op_e'(op_code))
      OP_BYTE: begin
        cmd.has_byte = 1'b1;
        cmd.finish   = 1'b0;
      end
      OP_BYTE_FIN: begin
        cmd.has_byte = 1'b1;
        cmd.finish   = 1'b1;
      end
      default: begin
        cmd.has_byte = 1'b0;
        cmd.finish   = 1'b1;
      end
    endcase
  end

  assign push_o.valid = data_i.valid && !full_i;
  assign push_o.cmd   = cmd;

endmodule

### rtl/cksum_queue.sv
// Small command queue that decouples the front end from the CRC engine.
module cksum_queue
  import cksum_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  input  logic    pop_i,
  output logic    full_o,
  output q_head_t head_o
);

  cmd_t                 entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = entries_q[rd_ptr_q];

  // Entry storage needs no reset; the count says what is live.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

### rtl/cksum_back.sv
// Back end: CRC engine, byte counter, length-byte sequencer and result register.
module cksum_back
  import cksum_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  cksum_out_if.source result_o
);

  typedef enum logic {
    ST_RUN,
    ST_LEN
  } state_e;

  state_e                 state_q, state_d;
  logic [31:0]            crc_q, crc_d;
  logic [CountBits-1:0]   cnt_q, cnt_d;
  logic [CountBits-1:0]   len_q, len_d;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            out_crc_q, out_crc_d;
  logic [ByteCountW-1:0]  out_cnt_q, out_cnt_d;
  logic [31:0]            crc_n;
  logic [CountBits-1:0]   cnt_n;

  assign result_o.valid      = out_valid_q;
  assign result_o.checksum   = out_crc_q;
  assign result_o.byte_count = out_cnt_q;

  // Fold the head byte, if any, into the running CRC and count.
  always_comb begin
    crc_n = head_i.cmd.has_byte ? crc_fold(crc_q, head_i.cmd.data) : crc_q;
    cnt_n = head_i.cmd.has_byte ? (cnt_q + CountBits'(1)) : cnt_q;
  end

  // Next-state logic: one byte per cycle, then the count bytes on finish.
  always_comb begin
    state_d     = state_q;
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    out_crc_d   = out_crc_q;
    out_cnt_d   = out_cnt_q;
    pop_o       = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_RUN: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          crc_d = crc_n;
          cnt_d = cnt_n;
          if (head_i.cmd.finish) begin
            len_d   = cnt_n;
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (len_q != '0) begin
          // Length bytes go in least significant first until none remain.
          crc_d = crc_fold(crc_q, len_q[7:0]);
          len_d = len_q >> 8;
        end else if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_crc_d   = crc_q ^ CrcXorOut;
          out_cnt_d   = ByteCountW'(cnt_q);
          crc_d       = '0;
          cnt_d       = '0;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // State, running CRC and count, and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      crc_q       <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      out_crc_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      crc_q       <= crc_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      out_crc_q   <= out_crc_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for posix_cksum_crc32: a directed table, a receiver-stall phase, then random messages.
module tb;
  import cksum_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The spare op code finishes a message just like OP_FIN.
  localparam logic [1:0] OpSpare = 2'd3;

  localparam int unsigned RandItems   = 700;
  localparam int unsigned LongHoldOff = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumDirected = 20;

  // One finished message as it leaves the block.
  typedef struct packed {
    logic [31:0]           checksum;
    logic [ByteCountW-1:0] byte_count;
  } cksum_t;

  // One row of the directed table; the result is typed in only where marked.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       typed;
    cksum_t     res;
  } dir_row_t;

  localparam cksum_t EmptyMsg = '{checksum: 32'hFFFF_FFFF, byte_count: '0};

  logic clk_i;
  logic rst_ni;

  cksum_in_if  req_if ();
  cksum_out_if res_if ();

  posix_cksum_crc32 dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (req_if),
    .result_o (res_if)
  );

  // Running state of the predictor.
  logic [31:0]          model_crc;
  logic [CountBits-1:0] model_len;

  // Checksums still to come out of the block, oldest first.
  cksum_t pending_sums[$];

  int unsigned errors       = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b1;
  logic        hold_off_req = 1'b0;

  dir_row_t dir_tab [NumDirected] = '{
    // Empty messages straight after reset, then one-byte messages at the extremes.
    '{OP_FIN,      8'h00, 1'b1, EmptyMsg},
    '{OpSpare,     8'hFF, 1'b1, EmptyMsg},
    '{OP_BYTE_FIN, 8'h00, 1'b0, '0},
    '{OP_BYTE_FIN, 8'hFF, 1'b0, '0},
    // A few bytes finished with a last byte.
    '{OP_BYTE,     8'h00, 1'b0, '0},
    '{OP_BYTE,     8'hFF, 1'b0, '0},
    '{OP_BYTE,     8'h80, 1'b0, '0},
    '{OP_BYTE_FIN, 8'h01, 1'b0, '0},
    // Finish without a byte; its data must be ignored.
    '{OP_BYTE,     8'hA5, 1'b0, '0},
    '{OP_BYTE,     8'h5A, 1'b0, '0},
    '{OP_FIN,      8'hFF, 1'b0, '0},
    // The spare code after some bytes.
    '{OP_BYTE,     8'h3C, 1'b0, '0},
    '{OpSpare,     8'h00, 1'b0, '0},
    // Empty messages with junk on the data byte.
    '{OP_FIN,      8'h7E, 1'b1, EmptyMsg},
    '{OpSpare,     8'h81, 1'b1, EmptyMsg},
    // Back-to-back finishing bytes.
    '{OP_BYTE_FIN, 8'h55, 1'b0, '0},
    '{OP_BYTE_FIN, 8'hAA, 1'b0, '0},
    '{OP_BYTE,     8'hC3, 1'b0, '0},
    '{OP_BYTE,     8'h0F, 1'b0, '0},
    '{OP_BYTE_FIN, 8'hF0, 1'b0, '0}
  };

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Safety net against a hung run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Serial MSB-first CRC-32 update by one byte.
  function automatic logic [31:0] crc_add_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] r;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      if (r[31] ^ b[k]) begin
        r = {r[30:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Advances the predictor by one accepted request and queues any checksum it yields.
  task automatic cksum_predict(input logic [1:0] op, input logic [7:0] data,
                               input logic typed, input cksum_t typed_res);
    logic [CountBits-1:0] n;
    logic [31:0]          crc;
    cksum_t               res;
    if (op == OP_BYTE || op == OP_BYTE_FIN) begin
      model_crc = crc_add_byte(model_crc, data);
      model_len = model_len + CountBits'(1);
    end
    if (op != OP_BYTE) begin
      // Fold the count in, low byte first, until nothing is left of it.
      crc = model_crc;
      n   = model_len;
      while (n != '0) begin
        crc = crc_add_byte(crc, n[7:0]);
        n   = n >> 8;
      end
      res.checksum   = crc ^ CrcXorOut;
      res.byte_count = ByteCountW'(model_len);
      pending_sums.push_back(typed ? typed_res : res);
      model_crc = '0;
      model_len = '0;
    end
  endtask

  // Offers one request, in bursts with random gaps, and predicts it once accepted.
  task automatic send_req(input logic [1:0] op, input logic [7:0] data,
                          input logic typed, input cksum_t typed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      if (!gaps_on) gap = 0;
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.data_byte <= data;
    do @(posedge clk_i); while (!req_if.ready);
    cksum_predict(op, data, typed, typed_res);
  endtask

  // Sends one message of the given length; how it is finished is chosen at random.
  task automatic send_message(input int unsigned len);
    int unsigned fin;
    logic [1:0]  op;
    fin = $urandom_range(0, 2);
    if (len == 0 && fin == 0) fin = 1;
    for (int unsigned i = 0; i < len; i++) begin
      op = (i == len - 1 && fin == 0) ? OP_BYTE_FIN : OP_BYTE;
      send_req(op, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    if (fin != 0) begin
      op = (fin == 1) ? OP_FIN : OpSpare;
      send_req(op, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  // Receiver: ready follows a duty cycle that changes every so often, plus one long hold-off.
  initial begin
    int unsigned ready_pct;
    int unsigned mode_left;
    bit          hold_done;
    ready_pct = 100;
    mode_left = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (LongHoldOff) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      res_if.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Result checker: every accepted checksum is matched against the oldest prediction.
  always @(posedge clk_i) begin : res_check
    cksum_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result checksum=%h byte_count=%h", $time,
                 res_if.checksum, res_if.byte_count);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (res_if.checksum !== want.checksum) begin
          $display("%0t: checksum mismatch: expected %h, actual %h", $time,
                   want.checksum, res_if.checksum);
          errors++;
        end
        if (res_if.byte_count !== want.byte_count) begin
          $display("%0t: byte_count mismatch: expected %h, actual %h", $time,
                   want.byte_count, res_if.byte_count);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, pressure phase, random messages, drain.
  initial begin
    int unsigned rand_items;
    int unsigned big_msgs;
    int unsigned roll;
    int unsigned len;
    rand_items = 0;
    big_msgs   = 0;
    model_crc  = '0;
    model_len  = '0;
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.op        <= OP_BYTE;
    req_if.data_byte <= 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].op, dir_tab[i].data, dir_tab[i].typed, dir_tab[i].res);
    end

    // Let everything drain, then stall the receiver while requests keep coming.
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    gaps_on = 1'b0;
    hold_off_req <= 1'b1;
    for (int unsigned m = 0; m < 12; m++) begin
      send_message($urandom_range(0, 3));
    end
    gaps_on = 1'b1;

    // Random messages, mostly short, a few long enough for a two-byte count.
    while (rand_items < RandItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_req($urandom_range(0, 1) ? OP_FIN : OpSpare, 8'($urandom_range(0, 255)),
                 1'b0, '0);
        rand_items++;
      end else begin
        if (roll < 11 && big_msgs < 2) begin
          len = $urandom_range(256, 320);
          big_msgs++;
        end else if (roll < 25) begin
          len = $urandom_range(13, 40);
        end else begin
          len = $urandom_range(0, 12);
        end
        send_message(len);
        rand_items += len + 1;
      end
    end

    req_if.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/cksum_pkg.sv
rtl/cksum_if.sv
rtl/cksum_front.sv
rtl/cksum_queue.sv
rtl/cksum_back.sv
rtl/posix_cksum_crc32.sv
tb/tb.sv
